// ===== rtl/tdcm_pkg.sv =====
// Shared types and constants of the tiled display cursor mapper.
// No dependencies; every other file of the block imports it.
package tdcm_pkg;

  localparam int DIV_W     = 11;  // dividend width of the shared divider
  localparam int DIVISOR_W = 8;   // divisor width of the shared divider

  localparam logic [15:0] COORD_MAX      = 16'hffff;
  localparam logic [5:0]  DEFAULT_FONT_W = 6'd6;
  localparam int          ROW_SHIFT      = 3;  // 8 pixel rows per character row

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_SET   = 2'd1,
    OP_PRINT = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_SELECT = 3'd1,
    CMD_WRITE  = 3'd2,
    CMD_REJECT = 3'd3,
    CMD_NOP    = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    REG_ACROSS  = 3'd0,
    REG_DOWN    = 3'd1,
    REG_COLUMNS = 3'd2,
    REG_ROWS    = 3'd3,
    REG_GRAPHIC = 3'd4,
    REG_FONT    = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    DIV_PANEL = 2'd0,
    DIV_COL   = 2'd1,
    DIV_ROW   = 2'd2
  } div_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_P_START,
    ST_P_WAIT,
    ST_P_MUL,
    ST_P_SUM,
    ST_P_CHECK,
    ST_CHECK,
    ST_X_START,
    ST_X_WAIT,
    ST_Y_START,
    ST_Y_WAIT,
    ST_SCALE,
    ST_EMIT_SEL,
    ST_EMIT_CHR,
    ST_EMIT_REJ,
    ST_EMIT_ONE
  } state_t;

  typedef struct packed {
    logic     in_load;
    logic     div_start;
    div_sel_t div_sel;
    logic     off_mul;
    logic     gsum;
    logic     cap_x;
    logic     scale;
    logic     cur_clear;
    logic     cur_invalidate;
    logic     cur_set;
    logic     cur_panel;
    logic     cur_advance;
    logic     out_load;
    cmd_t     out_kind;
    logic     out_last;
  } dp_cmd_t;

  typedef struct packed {
    op_t  new_op;
    op_t  op;
    logic div_busy;
    logic set_on_screen;
    logic cur_ok;
    logic panel_differs;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/tiled_display_cursor_mapper_core.sv =====
// Tiled display cursor mapper, top level: stream ports, controller, datapath.
// Depends on tdcm_pkg, tdcm_ctrl, tdcm_dp (which holds tdcm_div).
//
// Maps a cursor over a grid of identical panels tiled into one virtual screen.
// Each request carries an op in s_tuser: clear (one clear-all result, cursor
// homed), set cursor (panel-relative column/row turned into global ones;
// off-screen gives a reject and invalidates the cursor, else one
// select-and-place result), print (reject while the cursor is invalid or off
// screen, else an optional panel reselect followed by a write-char result,
// column advances with no wrap). Results leave on the m_ side with the result
// kind in m_tuser and m_tlast on the final result of a request. Requests are
// taken one at a time. Each request makes passes of the shared restoring divider
// (start, one step per quotient bit, then a check that it is done): three
// for an on-screen set, one for an off-screen set, two for a print. Clear,
// unused op and rejected print use no pass. A result waits while the output
// register is still full. The result sits in an output register, so the next
// request is taken while it waits. Config writes (cfg_we, cfg_index, cfg_data)
// must only happen while no request is in flight.
module tiled_display_cursor_mapper_core
  import tdcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // panel[7:0], col[18:8], row[29:19], char_code[37:30]
  input  logic [1:0]  s_tuser,   // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // device[5:0], pos_x[19:6], pos_y[30:20], char_out[38:31]
  output logic [2:0]  m_tuser,   // cmd[2:0]
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  logic [5:0]  out_device;
  logic [13:0] out_pos_x;
  logic [10:0] out_pos_y;
  logic [7:0]  out_char;

  tdcm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tdcm_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .in_op      (s_tuser),
    .in_panel   (s_tdata[7:0]),
    .in_col     (s_tdata[18:8]),
    .in_row     (s_tdata[29:19]),
    .in_char    (s_tdata[37:30]),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_cmd    (m_tuser),
    .out_device (out_device),
    .out_pos_x  (out_pos_x),
    .out_pos_y  (out_pos_y),
    .out_char   (out_char),
    .out_last   (m_tlast)
  );

  // pad to whole bytes
  assign m_tdata = {1'b0, out_char, out_pos_y, out_pos_x, out_device};

endmodule

// ===== rtl/tdcm_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on tdcm_pkg.
module tdcm_div
  import tdcm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_W-1:0]     dividend,
  input  logic [DIVISOR_W-1:0] divisor,
  output logic                 busy,
  output logic [DIV_W-1:0]     quo,
  output logic [DIVISOR_W-1:0] rem
);

  localparam int              CNT_W = $clog2(DIV_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_W - 1);

  logic [CNT_W-1:0]     cnt;
  logic [DIV_W-1:0]     quo_q;
  logic [DIVISOR_W-1:0] rem_q;
  logic [DIVISOR_W-1:0] dsr_q;
  logic [DIVISOR_W+1:0] diff;
  logic                 neg;

  assign diff = {1'b0, rem_q, quo_q[DIV_W-1]} - {2'b00, dsr_q};
  assign neg  = diff[DIVISOR_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == LAST) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_q <= dividend;
      rem_q <= '0;
      dsr_q <= divisor;
    end else if (busy) begin
      quo_q <= {quo_q[DIV_W-2:0], ~neg};
      rem_q <= neg ? {rem_q[DIVISOR_W-2:0], quo_q[DIV_W-1]} : diff[DIVISOR_W-1:0];
    end
  end

  assign quo = quo_q;
  assign rem = rem_q;

endmodule

// ===== rtl/tdcm_dp.sv =====
// Datapath: config registers, request capture, cursor state, coordinate math,
// shared divider and the output register. Depends on tdcm_pkg and tdcm_div.
module tdcm_dp
  import tdcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_panel,
  input  logic [10:0] in_col,
  input  logic [10:0] in_row,
  input  logic [7:0]  in_char,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_cmd,
  output logic [5:0]  out_device,
  output logic [13:0] out_pos_x,
  output logic [10:0] out_pos_y,
  output logic [7:0]  out_char,
  output logic        out_last
);

  // config registers
  logic [3:0] panels_across, panels_down;
  logic [7:0] panel_columns, panel_rows;
  logic       graphic_mode;
  logic [5:0] glyph_width;

  logic [3:0]  across, down;
  logic [7:0]  cols, rows;
  logic [5:0]  fw;
  logic [11:0] w_prod, h_prod;
  logic [10:0] full_w, full_h;

  // request
  op_t         op;
  logic [7:0]  pnl;
  logic [10:0] col, row;
  logic [7:0]  ch;

  // cursor
  logic [15:0] cursor_col, cursor_row;
  logic [5:0]  cursor_panel;
  logic        cursor_valid;

  // working registers
  logic [10:0] px_off, px_off_next;
  logic [15:0] py_off, py_off_next;
  logic [11:0] gx;
  logic [15:0] gy;
  logic [16:0] gy_sum;
  logic [2:0]  qx;
  logic [7:0]  rx;
  logic [5:0]  dev;
  logic [6:0]  dev_mul, dev_sum;
  logic [13:0] lx, lx_mul;
  logic [10:0] ly;

  // divider
  logic [DIV_W-1:0]     div_dividend, div_quo;
  logic [DIVISOR_W-1:0] div_divisor, div_rem;
  logic                 div_busy;

  // out-of-range register values act as the nearest legal one; glyph width 0 acts as DEFAULT_FONT_W
  assign across = (panels_across == 4'd0) ? 4'd1 : (panels_across > 4'd8) ? 4'd8 : panels_across;
  assign down   = (panels_down == 4'd0) ? 4'd1 : (panels_down > 4'd8) ? 4'd8 : panels_down;
  assign cols   = (panel_columns == 8'd0) ? 8'd1 : panel_columns;
  assign rows   = (panel_rows == 8'd0) ? 8'd1 : panel_rows;
  assign fw     = (glyph_width == 6'd0) ? DEFAULT_FONT_W : glyph_width;
  assign w_prod = across * cols;
  assign h_prod = down * rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      panels_across <= 4'd2;
      panels_down   <= 4'd1;
      panel_columns <= 8'd40;
      panel_rows    <= 8'd2;
      graphic_mode  <= 1'b0;
      glyph_width   <= 6'd6;
      full_w        <= 11'd80;
      full_h        <= 11'd2;
    end else begin
      full_w <= w_prod[10:0];
      full_h <= h_prod[10:0];
      if (cfg_we) begin
        case (cfg_index)
          REG_ACROSS:  panels_across <= cfg_data[3:0];
          REG_DOWN:    panels_down   <= cfg_data[3:0];
          REG_COLUMNS: panel_columns <= cfg_data;
          REG_ROWS:    panel_rows    <= cfg_data;
          REG_GRAPHIC: graphic_mode  <= cfg_data[0];
          REG_FONT:    glyph_width   <= cfg_data[5:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op <= OP_CLEAR;
    end else if (cmd.in_load) begin
      op <= op_t'(in_op);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      pnl <= in_panel;
      col <= in_col;
      row <= in_row;
      ch  <= in_char;
    end
  end

  // divider operand select
  always_comb begin
    case (cmd.div_sel)
      DIV_COL: begin
        div_dividend = cursor_col[DIV_W-1:0];
        div_divisor  = cols;
      end
      DIV_ROW: begin
        div_dividend = cursor_row[DIV_W-1:0];
        div_divisor  = rows;
      end
      default: begin
        div_dividend = {3'b000, pnl};
        div_divisor  = {4'b0000, across};
      end
    endcase
  end

  tdcm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // panel offsets: remainder < 8, quotient < 256
  assign px_off_next = div_rem[2:0] * cols;
  assign py_off_next = div_quo[7:0] * rows;
  assign gy_sum      = {6'b0, row} + {1'b0, py_off};

  assign dev_mul = div_quo[2:0] * across;
  assign dev_sum = dev_mul + {4'b0000, qx};
  assign lx_mul  = rx * fw;

  always_ff @(posedge clk) begin
    if (cmd.off_mul) begin
      px_off <= px_off_next;
      py_off <= py_off_next;
    end
    if (cmd.gsum) begin
      gx <= {1'b0, col} + {1'b0, px_off};
      gy <= gy_sum[16] ? COORD_MAX : gy_sum[15:0];
    end
    if (cmd.cap_x) begin
      qx <= div_quo[2:0];
      rx <= div_rem;
    end
    if (cmd.scale) begin
      dev <= dev_sum[5:0];
      lx  <= graphic_mode ? lx_mul : {6'b0, rx};
      ly  <= graphic_mode ? {div_rem, 3'b000} : {3'b000, div_rem};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col   <= '0;
      cursor_row   <= '0;
      cursor_panel <= '0;
      cursor_valid <= 1'b1;
    end else begin
      if (cmd.cur_clear) begin
        cursor_col   <= '0;
        cursor_row   <= '0;
        cursor_panel <= '0;
        cursor_valid <= 1'b1;
      end
      if (cmd.cur_invalidate) begin
        cursor_col   <= COORD_MAX;
        cursor_row   <= COORD_MAX;
        cursor_valid <= 1'b0;
      end
      if (cmd.cur_set) begin
        cursor_col   <= {4'b0, gx};
        cursor_row   <= gy;
        cursor_valid <= 1'b1;
      end
      if (cmd.cur_panel) begin
        cursor_panel <= dev;
      end
      if (cmd.cur_advance && cursor_col != COORD_MAX) begin
        cursor_col <= cursor_col + 16'd1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_cmd  <= cmd.out_kind;
      out_last <= cmd.out_last;
      if (cmd.out_kind == CMD_SELECT || cmd.out_kind == CMD_WRITE) begin
        out_device <= dev;
        out_pos_x  <= lx;
        out_pos_y  <= ly;
      end else begin
        out_device <= '0;
        out_pos_x  <= '0;
        out_pos_y  <= '0;
      end
      out_char <= (cmd.out_kind == CMD_WRITE) ? ch : 8'd0;
    end
  end

  assign status.new_op        = op_t'(in_op);
  assign status.op            = op;
  assign status.div_busy      = div_busy;
  assign status.set_on_screen = (gx < {1'b0, full_w}) && (gy < {5'b0, full_h});
  assign status.cur_ok        = cursor_valid && (cursor_col < {5'b0, full_w})
                                && (cursor_row < {5'b0, full_h});
  // checked in the scale cycle, while dev is still being loaded from dev_sum
  assign status.panel_differs = (dev_sum[5:0] != cursor_panel);
  assign status.out_free      = !out_valid || out_ready;

endmodule

// ===== rtl/tdcm_ctrl.sv =====
// Controller state machine: sequences the divider passes, checks and emits.
// Depends on tdcm_pkg.
module tdcm_ctrl
  import tdcm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (status.new_op)
            OP_SET:   state_next = ST_P_START;
            OP_PRINT: state_next = ST_CHECK;
            default:  state_next = ST_EMIT_ONE;
          endcase
        end
      end
      ST_P_START: state_next = ST_P_WAIT;
      ST_P_WAIT:  if (!status.div_busy) state_next = ST_P_MUL;
      ST_P_MUL:   state_next = ST_P_SUM;
      ST_P_SUM:   state_next = ST_P_CHECK;
      ST_P_CHECK: state_next = status.set_on_screen ? ST_X_START : ST_EMIT_REJ;
      ST_CHECK:   state_next = status.cur_ok ? ST_X_START : ST_EMIT_REJ;
      ST_X_START: state_next = ST_X_WAIT;
      ST_X_WAIT:  if (!status.div_busy) state_next = ST_Y_START;
      ST_Y_START: state_next = ST_Y_WAIT;
      ST_Y_WAIT:  if (!status.div_busy) state_next = ST_SCALE;
      ST_SCALE: begin
        if (status.op == OP_SET || status.panel_differs) begin
          state_next = ST_EMIT_SEL;
        end else begin
          state_next = ST_EMIT_CHR;
        end
      end
      ST_EMIT_SEL: begin
        if (status.out_free) begin
          state_next = (status.op == OP_SET) ? ST_IDLE : ST_EMIT_CHR;
        end
      end
      ST_EMIT_CHR, ST_EMIT_REJ, ST_EMIT_ONE: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.div_sel  = DIV_PANEL;
    cmd.out_kind = CMD_NOP;
    in_ready     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.in_load = in_valid;
      end
      ST_P_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_PANEL;
      end
      ST_P_MUL: cmd.off_mul = 1'b1;
      ST_P_SUM: cmd.gsum = 1'b1;
      ST_P_CHECK: cmd.cur_set = status.set_on_screen;
      ST_X_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_COL;
      end
      ST_Y_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_ROW;
        cmd.cap_x     = 1'b1;
      end
      ST_SCALE: cmd.scale = 1'b1;
      ST_EMIT_SEL: begin
        cmd.out_load  = status.out_free;
        cmd.out_kind  = CMD_SELECT;
        cmd.out_last  = (status.op == OP_SET);
        cmd.cur_panel = status.out_free;
      end
      ST_EMIT_CHR: begin
        cmd.out_load    = status.out_free;
        cmd.out_kind    = CMD_WRITE;
        cmd.out_last    = 1'b1;
        cmd.cur_advance = status.out_free;
      end
      ST_EMIT_REJ: begin
        cmd.out_load       = status.out_free;
        cmd.out_kind       = CMD_REJECT;
        cmd.out_last       = 1'b1;
        cmd.cur_invalidate = status.out_free && (status.op == OP_SET);
      end
      ST_EMIT_ONE: begin
        cmd.out_load  = status.out_free;
        cmd.out_kind  = (status.op == OP_CLEAR) ? CMD_CLEAR : CMD_NOP;
        cmd.out_last  = 1'b1;
        cmd.cur_clear = status.out_free && (status.op == OP_CLEAR);
      end
      default: ;
    endcase
  end

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for tiled_display_cursor_mapper_core: stream requests in,
// panel commands out, each result checked against an in-bench cursor tracker.
// Depends on tdcm_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb
  import tdcm_pkg::*;
();

  localparam int SETTLE_CYCLES    = 64;       // idle margin before config and at the end
  localparam int RANDOM_PER_PHASE = 105;
  localparam int CYCLE_LIMIT      = 1000000;

  // one request as it travels on the s_ side
  typedef struct packed {
    op_t        op;
    logic [7:0] panel;
    logic [10:0] col;
    logic [10:0] row;
    logic [7:0] char_code;
  } cursor_request_t;

  // one result as it travels on the m_ side
  typedef struct packed {
    cmd_t        cmd;
    logic [5:0]  device;
    logic [13:0] pos_x;
    logic [10:0] pos_y;
    logic [7:0]  char_out;
    logic        last;
  } panel_cmd_t;

  // raw register values; high bits may carry junk that the block must drop
  typedef struct packed {
    logic [7:0] across;
    logic [7:0] down;
    logic [7:0] columns;
    logic [7:0] rows;
    logic [7:0] graphic;
    logic [7:0] font;
  } panel_setup_t;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;     // panel[7:0], col[18:8], row[29:19], char_code[37:30]
  logic [1:0]  s_tuser = '0;     // op[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;          // device[5:0], pos_x[19:6], pos_y[30:20], char_out[38:31]
  logic [2:0]  m_tuser;          // cmd[2:0]
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  tiled_display_cursor_mapper_core uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Cursor tracker: bench copy of the registers and the cursor, reset values.
  // ---------------------------------------------------------------------------
  logic [3:0]  reg_across  = 4'd2;
  logic [3:0]  reg_down    = 4'd1;
  logic [7:0]  reg_columns = 8'd40;
  logic [7:0]  reg_rows    = 8'd2;
  logic        reg_graphic = 1'b0;
  logic [5:0]  reg_font    = 6'd6;

  logic [15:0] cur_col   = '0;
  logic [15:0] cur_row   = '0;
  logic [5:0]  cur_panel = '0;
  logic        cur_valid = 1'b1;

  cursor_request_t requests_todo[$];
  panel_cmd_t      panel_cmds_due[$];

  int mismatches = 0;

  // panel counts clamp to 1..8
  function automatic int unsigned tile_count(logic [3:0] v);
    if (v == 0) return 1;
    if (v > 8) return 8;
    return v;
  endfunction

  // panel sizes of 0 act as 1
  function automatic int unsigned span(logic [7:0] v);
    return (v == 0) ? 1 : v;
  endfunction

  // panel that owns a global cell, row-major over the tiling
  function automatic logic [5:0] tile_of(int unsigned gx, int unsigned gy);
    int unsigned idx;
    idx = gx / span(reg_columns) + (gy / span(reg_rows)) * tile_count(reg_across);
    return idx[5:0];
  endfunction

  // command carrying the cursor's local position; pixels in graphic mode
  function automatic panel_cmd_t placed_at(cmd_t kind, logic [5:0] dev, logic [7:0] ch,
                                           logic last);
    panel_cmd_t  res;
    int unsigned lx, ly, fw;
    fw = (reg_font == 0) ? DEFAULT_FONT_W : reg_font;
    lx = cur_col % span(reg_columns);
    ly = cur_row % span(reg_rows);
    if (reg_graphic) begin
      lx = lx * fw;
      ly = ly << ROW_SHIFT;
    end
    res          = '0;
    res.cmd      = kind;
    res.device   = dev;
    res.pos_x    = lx[13:0];
    res.pos_y    = ly[10:0];
    res.char_out = (kind == CMD_WRITE) ? ch : 8'h00;
    res.last     = last;
    return res;
  endfunction

  // advance the cursor for one accepted request and queue what it must produce
  task automatic map_cursor(cursor_request_t rq);
    int unsigned across, down, cols, rows, full_w, full_h, gx, gy;
    logic [5:0]  dev;
    panel_cmd_t  res;
    across = tile_count(reg_across);
    down   = tile_count(reg_down);
    cols   = span(reg_columns);
    rows   = span(reg_rows);
    full_w = across * cols;
    full_h = down * rows;
    res      = '0;
    res.last = 1'b1;
    case (rq.op)
      OP_CLEAR: begin
        cur_col   = '0;
        cur_row   = '0;
        cur_panel = '0;
        cur_valid = 1'b1;
        res.cmd   = CMD_CLEAR;
        panel_cmds_due.push_back(res);
      end
      OP_SET: begin
        gx = rq.col + (rq.panel % across) * cols;
        gy = rq.row + (rq.panel / across) * rows;
        if (gx > COORD_MAX) gx = COORD_MAX;
        if (gy > COORD_MAX) gy = COORD_MAX;
        if (gx >= full_w || gy >= full_h) begin
          // off screen: cursor parked at the far corner and invalidated
          cur_col   = COORD_MAX;
          cur_row   = COORD_MAX;
          cur_valid = 1'b0;
          res.cmd   = CMD_REJECT;
          panel_cmds_due.push_back(res);
        end else begin
          cur_col   = gx[15:0];
          cur_row   = gy[15:0];
          cur_valid = 1'b1;
          cur_panel = tile_of(gx, gy);
          panel_cmds_due.push_back(placed_at(CMD_SELECT, cur_panel, 8'h00, 1'b1));
        end
      end
      OP_PRINT: begin
        if (!cur_valid || cur_col >= full_w || cur_row >= full_h) begin
          res.cmd = CMD_REJECT;
          panel_cmds_due.push_back(res);
        end else begin
          dev = tile_of(cur_col, cur_row);
          // cursor walked onto another panel: reselect before the write
          if (dev != cur_panel) begin
            cur_panel = dev;
            panel_cmds_due.push_back(placed_at(CMD_SELECT, dev, 8'h00, 1'b0));
          end
          panel_cmds_due.push_back(placed_at(CMD_WRITE, dev, rq.char_code, 1'b1));
          if (cur_col < COORD_MAX) cur_col = cur_col + 16'd1;
        end
      end
      default: begin
        res.cmd = CMD_NOP;
        panel_cmds_due.push_back(res);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: bursts of random length, random gaps between them.
  // ---------------------------------------------------------------------------
  cursor_request_t in_flight;
  int burst_left = 1;
  int hold_gap   = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) map_cursor(in_flight);
      if (!s_tvalid || s_tready) begin
        if (hold_gap > 0) begin
          hold_gap--;
          s_tvalid <= 1'b0;
        end else if (requests_todo.size() > 0) begin
          in_flight = requests_todo.pop_front();
          s_tvalid  <= 1'b1;
          s_tdata   <= {2'b00, in_flight.char_code, in_flight.row, in_flight.col,
                        in_flight.panel};
          s_tuser   <= in_flight.op;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            // a quarter of the bursts run straight into the next one
            hold_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor; tready follows a random mode: always ready, coin toss or sparse.
  // ---------------------------------------------------------------------------
  rx_mode_t   rx_mode = RX_OPEN;
  int         rx_tick = 0;
  panel_cmd_t want, got;

  task automatic report_mismatch(string what);
    mismatches++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tuser, m_tdata[5:0], m_tdata[19:6], m_tdata[30:20], m_tdata[38:31],
               m_tlast};
        if (panel_cmds_due.size() == 0) begin
          report_mismatch($sformatf("result with none due, cmd %0d", m_tuser));
        end else begin
          want = panel_cmds_due.pop_front();
          if (got.cmd !== want.cmd)
            report_mismatch($sformatf("cmd %0d, want %0d", got.cmd, want.cmd));
          if (got.device !== want.device)
            report_mismatch($sformatf("device %0d, want %0d", got.device, want.device));
          if (got.pos_x !== want.pos_x)
            report_mismatch($sformatf("pos_x %0d, want %0d", got.pos_x, want.pos_x));
          if (got.pos_y !== want.pos_y)
            report_mismatch($sformatf("pos_y %0d, want %0d", got.pos_y, want.pos_y));
          if (got.char_out !== want.char_out)
            report_mismatch($sformatf("char_out %0h, want %0h", got.char_out,
                                      want.char_out));
          if (got.last !== want.last)
            report_mismatch($sformatf("tlast %0b, want %0b", got.last, want.last));
        end
      end
      rx_tick++;
      if (rx_tick % 256 == 0) rx_mode = rx_mode_t'($urandom_range(0, 2));
      case (rx_mode)
        RX_OPEN: m_tready <= 1'b1;
        RX_COIN: m_tready <= $urandom_range(0, 1);
        default: m_tready <= (rx_tick % 7 == 0);
      endcase
    end
  end

  // hard stop if the block hangs
  int cycles = 0;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_request(op_t op, int panel, int col, int row, int ch);
    cursor_request_t r;
    r.op        = op;
    r.panel     = panel[7:0];
    r.col       = col[10:0];
    r.row       = row[10:0];
    r.char_code = ch[7:0];
    requests_todo.push_back(r);
  endtask

  task automatic put_reg(reg_idx_t idx, logic [7:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_ACROSS:  reg_across  = value[3:0];
      REG_DOWN:    reg_down    = value[3:0];
      REG_COLUMNS: reg_columns = value;
      REG_ROWS:    reg_rows    = value;
      REG_GRAPHIC: reg_graphic = value[0];
      REG_FONT:    reg_font    = value[5:0];
      default: ;
    endcase
  endtask

  task automatic apply_setup(panel_setup_t s);
    put_reg(REG_ACROSS, s.across);
    put_reg(REG_DOWN, s.down);
    put_reg(REG_COLUMNS, s.columns);
    put_reg(REG_ROWS, s.rows);
    put_reg(REG_GRAPHIC, s.graphic);
    put_reg(REG_FONT, s.font);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // all requests taken, all results seen, then a quiet margin
  task automatic wait_idle();
    do @(negedge clk);
    while (requests_todo.size() != 0 || s_tvalid || panel_cmds_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic queue_random(int n);
    int made, pick, tiles, cols, rows, k, col, edge_off;
    made = 0;
    while (made < n) begin
      tiles = tile_count(reg_across) * tile_count(reg_down);
      cols  = span(reg_columns);
      rows  = span(reg_rows);
      pick  = $urandom_range(0, 99);
      if (pick < 55) begin
        // valid placement, often at a panel's right edge, then a run of prints
        edge_off = $urandom_range(0, 2);
        col = ($urandom_range(0, 2) == 0) ? ((cols - 1 > edge_off) ? cols - 1 - edge_off : 0)
                                          : $urandom_range(0, cols - 1);
        queue_request(OP_SET, $urandom_range(0, tiles - 1), col,
                      $urandom_range(0, rows - 1), $urandom);
        k = $urandom_range(1, 6);
        repeat (k) queue_request(OP_PRINT, $urandom, $urandom, $urandom, $urandom);
        made += k + 1;
      end else if (pick < 65) begin
        // coordinates relative to panel 0 that reach over the whole screen
        queue_request(OP_SET, 0, $urandom_range(0, tile_count(reg_across) * cols - 1),
                      $urandom_range(0, tile_count(reg_down) * rows - 1), $urandom);
        queue_request(OP_PRINT, $urandom, $urandom, $urandom, $urandom);
        made += 2;
      end else if (pick < 85) begin
        // noise: any op, any field
        queue_request(op_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom);
        made += 1;
      end else if (pick < 92) begin
        queue_request(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
        k = $urandom_range(1, 3);
        repeat (k) queue_request(OP_PRINT, $urandom, $urandom, $urandom, $urandom);
        made += k + 1;
      end else begin
        // panel past the tiling, then a print on the dead cursor
        queue_request(OP_SET, $urandom_range(tiles, 255), $urandom, $urandom, $urandom);
        queue_request(OP_PRINT, $urandom, $urandom, $urandom, $urandom);
        made += 2;
      end
    end
  endtask

  panel_setup_t setups[$];

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset layout: two 40x2 character panels side by side
    queue_request(OP_CLEAR, 0, 0, 0, 0);
    queue_request(OP_SET, 0, 0, 0, 0);
    queue_request(OP_PRINT, 0, 0, 0, 8'h00);
    queue_request(OP_PRINT, 255, 2047, 2047, 8'hff);
    queue_request(OP_SET, 1, 39, 1, 0);           // last cell of the screen
    queue_request(OP_PRINT, 0, 0, 0, 8'h41);
    queue_request(OP_PRINT, 0, 0, 0, 8'h42);      // past the right edge
    queue_request(OP_SET, 0, 39, 0, 0);
    queue_request(OP_PRINT, 0, 0, 0, 8'h43);
    queue_request(OP_PRINT, 0, 0, 0, 8'h44);      // walks onto panel 1: reselect
    queue_request(OP_SET, 0, 2047, 2047, 0);      // off screen
    queue_request(OP_PRINT, 0, 0, 0, 8'h45);      // cursor invalid
    queue_request(OP_NONE, 255, 2047, 2047, 255);
    queue_request(OP_NONE, 0, 0, 0, 0);
    queue_request(OP_CLEAR, 255, 2047, 2047, 255);
    queue_request(OP_PRINT, 0, 0, 0, 8'h7f);
    queue_request(OP_SET, 255, 0, 0, 0);
    queue_request(OP_SET, 1, 0, 0, 0);
    queue_request(OP_SET, 0, 79, 1, 0);           // relative column lands on panel 1
    queue_request(OP_SET, 2, 0, 0, 0);            // panel below the tiling
    queue_request(OP_CLEAR, 0, 0, 0, 0);
    wait_idle();

    setups.push_back({8'd1, 8'd1, 8'd1, 8'd1, 8'd0, 8'd1});          // smallest
    setups.push_back({8'd8, 8'd8, 8'd255, 8'd255, 8'd1, 8'd63});     // largest, pixels
    setups.push_back({8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0});          // zeros fall back
    setups.push_back({8'd15, 8'd9, 8'd40, 8'd2, 8'hfe, 8'hc5});      // clamps, junk bits
    setups.push_back({8'd1, 8'd8, 8'd255, 8'd255, 8'd0, 8'd63});     // row saturation
    repeat (2)
      setups.push_back({8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)),
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom), 8'($urandom)});

    foreach (setups[i]) begin
      apply_setup(setups[i]);
      queue_request(OP_CLEAR, 0, 0, 0, 0);
      queue_request(OP_SET, 255, 2047, 2047, 255);
      queue_request(OP_PRINT, 0, 0, 0, 8'h55);
      queue_request(OP_SET, 0, 0, 0, 0);
      queue_request(OP_PRINT, 0, 0, 0, 8'hff);
      queue_request(OP_NONE, 255, 2047, 2047, 255);
      queue_random(RANDOM_PER_PHASE);
      wait_idle();
    end

    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
